// File: rtl/core/pncm_pkg.sv
`timescale 1ns / 1ps

package pncm_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned IdxW         = $clog2(PaletteDepth);
  localparam int unsigned CntW         = $clog2(PaletteDepth + 1);
  localparam int unsigned ChanW        = 8;
  localparam int unsigned FieldIdxW    = 8;
  localparam int unsigned DistW        = 18;
  localparam int unsigned InDataW      = 32;
  localparam int unsigned OutDataW     = 8;
  localparam int unsigned CfgAddrW     = 1;
  localparam int unsigned CfgDataW     = 9;

  localparam logic [CfgAddrW-1:0] RegPaletteSize  = 1'b0;
  localparam logic [CfgAddrW-1:0] RegPaletteReady = 1'b1;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } pncm_state_e;

endpackage

// File: rtl/core/palette_nearest_color_match.sv
`timescale 1ns / 1ps

// Channel  | Dir | Fields (lsb first)
// s_axis   | in  | tdata: entry_index, red, green, blue; tuser: mode
// m_axis   | out | tdata: nearest_idx
// cfg      | in  | cfg_addr_i 0: palette_size, 1: palette_ready
//
// A query scans one palette entry per cycle through the synchronous memory read port,
// stopping early on an exact match; it skips the scan when the palette is not ready
// or holds fewer than two entries.
// Reset clears control and configuration; palette contents stay undefined until written.
// A stalled result sits in the output register; palette writes are still accepted while no query is in progress.
module palette_nearest_color_match (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pncm_pkg::InDataW-1:0]     s_axis_tdata,  // entry_index, red, green, blue
  input  logic                             s_axis_tuser,  // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pncm_pkg::OutDataW-1:0]    m_axis_tdata,  // nearest_idx
  input  logic                             cfg_we_i,
  input  logic [pncm_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [pncm_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import pncm_pkg::*;

  pncm_state_e          state_q, state_d;
  logic [CntW-1:0]      size_q;
  logic                 ready_q;
  logic [ChanW-1:0]     red_q, green_q, blue_q;
  logic [ChanW-1:0]     red_d, green_d, blue_d;
  logic [CntW-1:0]      iss_q, iss_d, end_q, end_d;
  logic                 mono_q, mono_d;
  logic                 rv_q, rv_d, dv_q, dv_d;
  logic [IdxW-1:0]      ridx_q, didx_q;
  logic [DistW-1:0]     dist_q, dist_d;
  logic [DistW-1:0]     best_dist_q, best_dist_d;
  logic [IdxW-1:0]      best_q, best_d;
  logic                 out_valid_q, out_valid_d;
  logic [OutDataW-1:0]  out_data_q, out_data_d;
  logic [3*ChanW-1:0]   mem [PaletteDepth];
  logic [3*ChanW-1:0]   rd_data_q;

  logic                 in_acc, wr_en, issue, hit, drain, load_out;
  logic [CntW-1:0]      n_eff;
  logic [FieldIdxW-1:0] in_idx;

  function automatic logic [2*ChanW-1:0] sq_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[FieldIdxW-1:0];
  assign wr_en         = in_acc && (s_axis_tuser == ModeWrite) &&
                         ({1'b0, in_idx} < (FieldIdxW+1)'(PaletteDepth));
  assign n_eff         = (size_q > CntW'(PaletteDepth)) ? CntW'(PaletteDepth) : size_q;

  assign hit   = dv_q && (dist_q == '0);
  assign drain = (iss_q == end_q) && !rv_q && !dv_q;
  assign issue = (state_q == StScan) && (iss_q != end_q) && !hit;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '0;
      ready_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegPaletteSize:  size_q  <= cfg_wdata_i[CntW-1:0];
        RegPaletteReady: ready_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_idx[IdxW-1:0]] <= s_axis_tdata[FieldIdxW +: 3*ChanW];
    end
    if (issue) begin
      rd_data_q <= mem[iss_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rv_q        <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      iss_q       <= '0;
      end_q       <= '0;
      mono_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
      iss_q       <= iss_d;
      end_q       <= end_d;
      mono_q      <= mono_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q       <= red_d;
    green_q     <= green_d;
    blue_q      <= blue_d;
    ridx_q      <= iss_q[IdxW-1:0];
    didx_q      <= ridx_q;
    dist_q      <= dist_d;
    best_dist_q <= best_dist_d;
    best_q      <= best_d;
    out_data_q  <= out_data_d;
  end

  // distance of the entry read last cycle; entries hold red, green, blue from the lsb up
  assign dist_d = DistW'(sq_diff(red_q,   rd_data_q[0 +: ChanW])) +
                  DistW'(sq_diff(green_q, rd_data_q[ChanW +: ChanW])) +
                  DistW'(sq_diff(blue_q,  rd_data_q[2*ChanW +: ChanW]));

  always_comb begin
    state_d     = state_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    iss_d       = iss_q;
    end_d       = end_q;
    mono_d      = mono_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    rv_d        = issue;
    dv_d        = rv_q && !hit;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_acc && (s_axis_tuser == ModeQuery)) begin
          red_d       = s_axis_tdata[FieldIdxW +: ChanW];
          green_d     = s_axis_tdata[FieldIdxW+ChanW +: ChanW];
          blue_d      = s_axis_tdata[FieldIdxW+2*ChanW +: ChanW];
          best_d      = '0;
          best_dist_d = '1;
          end_d       = n_eff;
          mono_d      = (n_eff == CntW'(2));
          // two-entry palette only checks entry 1 for an exact match
          iss_d       = (n_eff == CntW'(2)) ? CntW'(1) : '0;
          if (!ready_q || (n_eff < CntW'(2))) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (issue) begin
          iss_d = iss_q + CntW'(1);
        end
        if (hit) begin
          best_d  = didx_q;
          state_d = StDone;
        end else begin
          if (dv_q && !mono_q && (dist_q < best_dist_q)) begin
            best_d      = didx_q;
            best_dist_d = dist_q;
          end
          if (drain) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = OutDataW'(best_q);
    end
  end

endmodule

// File: rtl/core/pncm_checker.sv
`timescale 1ns / 1ps

module pncm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pncm_pkg::OutDataW-1:0] m_axis_tdata
);
  import pncm_pkg::*;

  // the input stays ready in the cycle after a palette write
  a_write_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ModeWrite)) |=> s_axis_tready)
    else $error("input not ready after palette write");

  // an accepted query always moves the sequencer out of idle, so the input drops ready
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ModeQuery)) |=> !s_axis_tready)
    else $error("input ready right after query");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind palette_nearest_color_match pncm_checker u_pncm_checker (.*);

// File: verif/palette_nearest_color_match_tb.sv
`timescale 1ns / 1ps

module palette_nearest_color_match_tb;
  import pncm_pkg::*;

  class palette_match_scoreboard;
    logic [23:0]          palette [PaletteDepth];  // {red, green, blue}
    logic [CfgDataW-1:0]  palette_size;
    logic                 palette_ready;
    logic [OutDataW-1:0]  expected_index_q [$];
    int unsigned          errors;

    function new();
      foreach (palette[i]) palette[i] = '0;
      palette_size  = '0;
      palette_ready = 1'b0;
      errors        = 0;
    endfunction

    function void set_register(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] value);
      if (addr == RegPaletteSize) begin
        palette_size = value;
      end else if (addr == RegPaletteReady) begin
        palette_ready = value[0];
      end
    endfunction

    function int unsigned sq_diff(logic [7:0] a, logic [7:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
    endfunction

    function logic [OutDataW-1:0] nearest_entry(logic [23:0] c);
      int unsigned n, i, d, best, best_d;
      if (!palette_ready) return '0;
      n = (palette_size > PaletteDepth) ? PaletteDepth : palette_size;
      // two-entry palette is treated as monochrome
      if (n == 2) return (palette[1] == c) ? OutDataW'(1) : '0;
      best   = 0;
      best_d = 32'hffff_ffff;
      for (i = 0; i < n; i++) begin
        d = sq_diff(c[23:16], palette[i][23:16]) + sq_diff(c[15:8], palette[i][15:8])
          + sq_diff(c[7:0], palette[i][7:0]);
        if (d == 0) return OutDataW'(i);
        if (d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      return OutDataW'(best);
    endfunction

    function void note_input(logic mode, logic [7:0] idx, logic [23:0] c);
      if (mode == ModeWrite) begin
        palette[idx] = c;
      end else begin
        expected_index_q.push_back(nearest_entry(c));
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [OutDataW-1:0] got);
      logic [OutDataW-1:0] want;
      if (expected_index_q.size() == 0) begin
        report($sformatf("nearest_idx %0d with no pending query", got));
        return;
      end
      want = expected_index_q.pop_front();
      if (got !== want) report($sformatf("nearest_idx got %0d expected %0d", got, want));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;   // entry_index, red, green, blue
  logic                  s_axis_tuser  = 1'b0; // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;         // nearest_idx
  logic                  cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0]   cfg_addr_i    = '0;
  logic [CfgDataW-1:0]   cfg_wdata_i   = '0;

  palette_match_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned burst_left;
  // toggled by the sender to ask the receiver for a long hold-off
  logic        long_hold_req = 1'b0;

  palette_nearest_color_match u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random stall patterns, plus long hold-offs on request
  initial begin
    int unsigned stall_mode, mode_left, hold_left;
    logic        hold_seen;
    mode_left = 0;
    hold_left = 0;
    stall_mode = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if ((long_hold_req != hold_seen) && hold_left == 0) begin
        hold_left = 500;
        hold_seen = long_hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((mode_left % 7) < 3);
        endcase
      end
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] idx, input logic [23:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c[7:0], c[15:8], c[23:16], idx};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(mode, idx, c);
    items_sent++;
  endtask

  task automatic query(input logic [23:0] c);
    send_item(ModeQuery, 8'($urandom_range(0, 255)), c);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_index_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned size, input logic ready);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegPaletteSize;
    cfg_wdata_i <= CfgDataW'(size);
    @(posedge clk_i);
    cfg_addr_i  <= RegPaletteReady;
    cfg_wdata_i <= CfgDataW'(ready);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(RegPaletteSize, CfgDataW'(size));
    sb.set_register(RegPaletteReady, CfgDataW'(ready));
    @(posedge clk_i);
  endtask

  // exact copies, near misses, tie-prone levels, or uniform colors
  function automatic logic [23:0] pick_color(int unsigned span);
    logic [23:0] c;
    int unsigned sel, k;
    int v;
    sel = $urandom_range(0, 9);
    c = 24'($urandom);
    if (span > 0 && sel < 5) begin
      c = sb.palette[$urandom_range(0, span - 1)];
      if (sel >= 3) begin
        for (k = 0; k < 3; k++) begin
          v = int'(c[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
          c[8*k +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
        end
      end
    end else if (sel < 8) begin
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(0, 7))
          0:       c[8*k +: 8] = 8'd0;
          1:       c[8*k +: 8] = 8'd1;
          2:       c[8*k +: 8] = 8'd2;
          3:       c[8*k +: 8] = 8'd3;
          4:       c[8*k +: 8] = 8'd127;
          5:       c[8*k +: 8] = 8'd128;
          6:       c[8*k +: 8] = 8'd254;
          default: c[8*k +: 8] = 8'd255;
        endcase
      end
    end
    return c;
  endfunction

  task automatic run_phase(input int unsigned size, input logic ready, input int unsigned count);
    int unsigned n, k;
    logic [7:0]  idx;
    logic [23:0] c;
    configure(size, ready);
    n = (size > PaletteDepth) ? PaletteDepth : size;
    for (k = 0; k < count; k++) begin
      if (n > 0 && $urandom_range(0, 9) < 7) idx = 8'($urandom_range(0, n - 1));
      else idx = 8'($urandom_range(0, 255));
      c = pick_color(n);
      send_item(($urandom_range(0, 9) < 4) ? ModeWrite : ModeQuery, idx, c);
    end
  endtask

  initial begin
    int unsigned k, sel, size, phase_no;
    logic ready;
    items_sent = 0;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // not ready: always index 0
    configure(0, 1'b0);
    query(24'h000000);
    query(24'hffffff);
    send_item(ModeWrite, 8'd0, 24'h000000);
    send_item(ModeWrite, 8'd1, 24'hffffff);
    send_item(ModeWrite, 8'd2, 24'hff0080);
    send_item(ModeWrite, 8'd3, 24'h020000);
    send_item(ModeWrite, 8'd255, 24'haa550f);
    configure(2, 1'b0);
    query(24'hffffff);
    // empty and single-entry palettes
    configure(0, 1'b1);
    query(24'hffffff);
    configure(1, 1'b1);
    query(24'hffffff);
    // monochrome
    configure(2, 1'b1);
    query(24'hffffff);
    query(24'hfeffff);
    query(24'h000000);
    // full search: exact, near, tie between entries 0 and 3
    configure(4, 1'b1);
    query(24'hff0080);
    query(24'hfa0a78);
    query(24'h010000);
    query(24'h020000);
    query(24'h808080);

    // load the whole palette
    configure(4, 1'b0);
    for (k = 0; k < PaletteDepth; k++) send_item(ModeWrite, 8'(k), pick_color(k));

    // largest sizes, including values beyond the depth
    configure(256, 1'b1);
    query(sb.palette[255]);
    query(24'($urandom));
    configure(300, 1'b1);
    query(sb.palette[255]);
    query(24'($urandom));
    configure(511, 1'b1);
    query(sb.palette[255]);
    configure(255, 1'b1);
    query(sb.palette[255]);
    query(24'($urandom));

    phase_no = 0;
    while (items_sent < 1300) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) size = $urandom_range(0, 1);
      else if (sel < 12) size = 2;
      else if (sel < 20) size = $urandom_range(255, 256);
      else if (sel < 24) size = $urandom_range(257, 511);
      else size = $urandom_range(3, 24);
      ready = ($urandom_range(0, 99) < 85);
      if (phase_no == 2 || phase_no == 25) begin
        configure(8, 1'b1);
        long_hold_req <= ~long_hold_req;
        run_phase(8, 1'b1, 40);
      end else begin
        run_phase(size, ready, $urandom_range(10, 40));
      end
      phase_no++;
    end

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pncm_pkg.sv
rtl/core/palette_nearest_color_match.sv
rtl/core/pncm_checker.sv
verif/palette_nearest_color_match_tb.sv
